// File: rtl/pq_nearest_centroid_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// PQ encoder assertion macros
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef PQ_NEAREST_CENTROID_ENCODER_UNIT_DEFINES_SVH
`define PQ_NEAREST_CENTROID_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication
`define PQNCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PQNCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pqnce_pkg.sv
// ----------------------------------------------------------------------------
// PQ encoder package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pqnce_pkg;

  localparam int SUBSPACES  = 8;
  localparam int CODES      = 256;
  localparam int SUBDIM     = 4;
  localparam int LANES      = 4;
  localparam int ELEM_W     = 16;
  localparam int SQ_W       = 2 * ELEM_W;
  localparam int SUB_W      = 3;
  localparam int IN_IDX_W   = 8;
  localparam int CODE_W     = 8;
  localparam int DIST_W     = 34;
  localparam int IDX_W      = $clog2(CODES);
  localparam int BOOK_DEPTH = SUBSPACES * CODES;
  localparam int ADDR_W     = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int BOOK_W     = SUBDIM * ELEM_W;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef enum logic [1:0] {
    FN_ENCODE = 2'd0,
    FN_WRITE  = 2'd1,
    FN_READ   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    OSEL_ZERO = 2'd0,
    OSEL_ENC  = 2'd1,
    OSEL_READ = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic     start;
    logic     issue;
    logic     rd;
    logic     wr;
    logic     load_out;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  sub_ok;
    logic  idx_ok;
    logic  cnt_last;
    logic  enc_done;
  } dp_sts_t;

endpackage

// File: rtl/pq_nearest_centroid_encoder_unit.sv
// ----------------------------------------------------------------------------
// PQ nearest-centroid encoder
// Codebook of Q7.8 centroids; writes, reads back or encodes to the nearest one.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | func, subspace, centroid_index, elem_0..3
//  out      | out_valid / out_stall| code, distance, value_0..3
//
//  Encode: one codebook read per cycle from the
//  single-port RAM, then four pipeline stages to drain.
//  Write and read take one RAM access each; other requests go straight to the result.
//  Sync reset clears control only; codebook contents are undefined until written.
//  A held result does not block the next request; a finished one waits while a
//  held result is stalled by out_stall.
// ----------------------------------------------------------------------------
`include "pq_nearest_centroid_encoder_unit_defines.svh"

module pq_nearest_centroid_encoder_unit
  import pqnce_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic [SUB_W-1:0]    in_subspace,
  input  logic [IN_IDX_W-1:0] in_centroid_index,
  input  logic signed [15:0]  in_elem_0,
  input  logic signed [15:0]  in_elem_1,
  input  logic signed [15:0]  in_elem_2,
  input  logic signed [15:0]  in_elem_3,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CODE_W-1:0]   out_code,
  output logic [DIST_W-1:0]   out_distance,
  output logic signed [15:0]  out_value_0,
  output logic signed [15:0]  out_value_1,
  output logic signed [15:0]  out_value_2,
  output logic signed [15:0]  out_value_3
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  elem_t   elem [LANES];
  elem_t   value [LANES];

  assign elem[0] = in_elem_0;
  assign elem[1] = in_elem_1;
  assign elem[2] = in_elem_2;
  assign elem[3] = in_elem_3;

  pqnce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  pqnce_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_subspace       (in_subspace),
    .in_centroid_index (in_centroid_index),
    .in_elem           (elem),
    .out_code          (out_code),
    .out_distance      (out_distance),
    .out_value         (value)
  );

  assign out_value_0 = value[0];
  assign out_value_1 = value[1];
  assign out_value_2 = value[2];
  assign out_value_3 = value[3];

  `PQNCE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted twice")
  `PQNCE_ASSERT_NOW(a_ram_port_excl, cmd.wr, !cmd.issue && !cmd.rd, "RAM port conflict")
  `PQNCE_ASSERT_NOW(a_load_when_free, cmd.load_out, !out_valid || !out_stall, "result lost")
  `PQNCE_ASSERT_NEXT(a_zero_code, cmd.load_out && cmd.out_sel != OSEL_ENC, out_code == '0 && out_distance == '0, "nonzero code")

endmodule

// File: rtl/pqnce_ram.sv
// ----------------------------------------------------------------------------
// PQ encoder RAM
// Single-port RAM, one write or one registered read per cycle, no reset.
// ----------------------------------------------------------------------------
module pqnce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pqnce_dp.sv
// ----------------------------------------------------------------------------
// PQ encoder datapath
// Item registers, codebook RAM, distance pipeline, best tracker, result regs.
// ----------------------------------------------------------------------------
module pqnce_dp
  import pqnce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [1:0]           in_func,
  input  logic [SUB_W-1:0]     in_subspace,
  input  logic [IN_IDX_W-1:0]  in_centroid_index,
  input  elem_t                in_elem [LANES],
  output logic [CODE_W-1:0]    out_code,
  output logic [DIST_W-1:0]    out_distance,
  output elem_t                out_value [LANES]
);

  logic [1:0]          func_r;
  logic [SUB_W-1:0]    sub_r;
  logic [IN_IDX_W-1:0] idx_r;
  elem_t               x_r [SUBDIM];
  logic [IDX_W-1:0]    cnt_r;

  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   addr;
  logic [BOOK_W-1:0]   wdata;
  logic [BOOK_W-1:0]   rdata;

  // pipeline tags
  logic                p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic                p1_last_r, p2_last_r, p3_last_r, p4_last_r;
  logic [IDX_W-1:0]    p1_idx_r, p2_idx_r, p3_idx_r, p4_idx_r;
  logic [ELEM_W-1:0]   p2_abs_r [SUBDIM];
  logic [SQ_W-1:0]     p3_sq_r [SUBDIM];
  logic [DIST_W-1:0]   p4_sum_r;
  logic [DIST_W-1:0]   sum;
  logic [DIST_W-1:0]   best_d_r;
  logic [IDX_W-1:0]    best_i_r;

  logic [CODE_W-1:0]   code_r;
  logic [DIST_W-1:0]   dist_r;
  elem_t               val_r [LANES];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r <= in_func;
      sub_r  <= in_subspace;
      idx_r  <= in_centroid_index;
      for (int j = 0; j < SUBDIM; j++) begin
        x_r[j] <= in_elem[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt_r <= '0;
    end else if (cmd.issue) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts.func     = func_t'(func_r);
  assign sts.sub_ok   = ({1'b0, sub_r} < (SUB_W + 1)'(SUBSPACES));
  assign sts.idx_ok   = ({1'b0, idx_r} < (IN_IDX_W + 1)'(CODES));
  assign sts.cnt_last = (cnt_r == IDX_W'(CODES - 1));
  assign sts.enc_done = p4_v_r && p4_last_r;

  assign base = ADDR_W'(sub_r) * ADDR_W'(CODES);
  assign addr = base + ADDR_W'(cmd.issue ? cnt_r : idx_r[IDX_W-1:0]);

  always_comb begin
    for (int j = 0; j < SUBDIM; j++) begin
      wdata[j*ELEM_W +: ELEM_W] = x_r[j];
    end
  end

  pqnce_ram #(
    .WIDTH (BOOK_W),
    .DEPTH (BOOK_DEPTH)
  ) u_book (
    .clk   (clk),
    .we    (cmd.wr),
    .re    (cmd.issue || cmd.rd),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else begin
      p1_v_r <= cmd.issue;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_last_r <= sts.cnt_last;
    p1_idx_r  <= cnt_r;
    p2_last_r <= p1_last_r;
    p2_idx_r  <= p1_idx_r;
    p3_last_r <= p2_last_r;
    p3_idx_r  <= p2_idx_r;
    p4_last_r <= p3_last_r;
    p4_idx_r  <= p3_idx_r;
  end

  // |x - c| per lane
  always_ff @(posedge clk) begin
    for (int j = 0; j < SUBDIM; j++) begin
      logic signed [ELEM_W:0] d;
      d = {x_r[j][ELEM_W-1], x_r[j]}
        - {rdata[j*ELEM_W + ELEM_W - 1], rdata[j*ELEM_W +: ELEM_W]};
      p2_abs_r[j] <= d[ELEM_W] ? ELEM_W'(-d) : d[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SUBDIM; j++) begin
      p3_sq_r[j] <= SQ_W'(p2_abs_r[j]) * SQ_W'(p2_abs_r[j]);
    end
  end

  always_comb begin
    sum = '0;
    for (int j = 0; j < SUBDIM; j++) begin
      sum = sum + DIST_W'(p3_sq_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    p4_sum_r <= sum;
  end

  // strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (p4_v_r && ((p4_idx_r == '0) || (p4_sum_r < best_d_r))) begin
      best_d_r <= p4_sum_r;
      best_i_r <= p4_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      code_r <= '0;
      dist_r <= '0;
      for (int j = 0; j < LANES; j++) begin
        val_r[j] <= '0;
      end
      case (cmd.out_sel)
        OSEL_ENC: begin
          code_r <= CODE_W'(best_i_r);
          dist_r <= best_d_r;
        end
        OSEL_READ: begin
          for (int j = 0; j < SUBDIM; j++) begin
            val_r[j] <= rdata[j*ELEM_W +: ELEM_W];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_code     = code_r;
  assign out_distance = dist_r;
  assign out_value    = val_r;

endmodule

// File: rtl/pqnce_ctrl.sv
// ----------------------------------------------------------------------------
// PQ encoder controller
// Sequences one request at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module pqnce_ctrl
  import pqnce_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_ENC   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_WR    = 7'b0010000,
    S_RD    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t   state_r, state_nxt;
  out_sel_t sel_r, sel_nxt;
  logic     out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cmd           = '0;
    cmd.out_sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        sel_nxt   = OSEL_ZERO;
        state_nxt = S_DONE;
        if (sts.sub_ok) begin
          case (sts.func)
            FN_ENCODE: begin
              sel_nxt   = OSEL_ENC;
              state_nxt = S_ENC;
            end
            FN_WRITE: begin
              if (sts.idx_ok) begin
                state_nxt = S_WR;
              end
            end
            FN_READ: begin
              if (sts.idx_ok) begin
                sel_nxt   = OSEL_READ;
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_ENC: begin
        cmd.issue = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.enc_done) begin
          state_nxt = S_DONE;
        end
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= OSEL_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: tb/pq_encode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PQ encoder result checker
// Watches both channels. Each accepted request is applied to a private codebook
// copy and queues the answer it should produce. Each accepted result is compared
// field by field with the oldest queued answer.
// ----------------------------------------------------------------------------
module pq_encode_checker
  import pqnce_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic [SUB_W-1:0]    in_subspace,
  input  logic [IN_IDX_W-1:0] in_centroid_index,
  input  logic signed [15:0]  in_elem_0,
  input  logic signed [15:0]  in_elem_1,
  input  logic signed [15:0]  in_elem_2,
  input  logic signed [15:0]  in_elem_3,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [CODE_W-1:0]   out_code,
  input  logic [DIST_W-1:0]   out_distance,
  input  logic signed [15:0]  out_value_0,
  input  logic signed [15:0]  out_value_1,
  input  logic signed [15:0]  out_value_2,
  input  logic signed [15:0]  out_value_3,
  output int                  error_count,
  output int                  pending_count
);

  typedef struct packed {
    logic [CODE_W-1:0]             code;
    logic [DIST_W-1:0]             distance;
    logic [LANES-1:0][ELEM_W-1:0]  value;
  } answer_t;

  elem_t   book_copy [BOOK_DEPTH][LANES];
  answer_t answers [$];
  int      mismatch_count = 0;

  assign error_count = mismatch_count;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Applies one request to the codebook copy and returns its answer.
  function automatic answer_t nearest_centroid_answer(
    input logic [1:0]                 func,
    input logic [SUB_W-1:0]           sub,
    input logic [IN_IDX_W-1:0]        idx,
    input logic [LANES-1:0][ELEM_W-1:0] x
  );
    answer_t a;
    int      base;
    int      j;
    int      k;
    longint  best;
    longint  cand_d;
    longint  diff;
    a = '0;
    if (int'(sub) >= SUBSPACES) return a;
    base = int'(sub) * CODES;
    case (func)
      FN_ENCODE: begin
        best = 0;
        for (k = 0; k < CODES; k++) begin
          cand_d = 0;
          for (j = 0; j < SUBDIM; j++) begin
            diff = longint'(elem_t'(x[j])) - longint'(book_copy[base + k][j]);
            cand_d += diff * diff;
          end
          if (k == 0 || cand_d < best) begin
            best   = cand_d;
            a.code = CODE_W'(k);
          end
        end
        a.distance = best[DIST_W-1:0];
      end
      FN_WRITE: begin
        if (int'(idx) < CODES)
          for (j = 0; j < SUBDIM; j++) book_copy[base + int'(idx)][j] = elem_t'(x[j]);
      end
      FN_READ: begin
        if (int'(idx) < CODES)
          for (j = 0; j < SUBDIM; j++) a.value[j] = book_copy[base + int'(idx)][j];
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t                      want;
    logic [LANES-1:0][ELEM_W-1:0] got;
    int                           j;
    if (rst_n) begin
      if (in_valid && !in_stall)
        answers.push_back(nearest_centroid_answer(in_func, in_subspace, in_centroid_index,
                                                  {in_elem_3, in_elem_2, in_elem_1, in_elem_0}));
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          report($sformatf("result with no request pending: code %0d distance %0d",
                           out_code, out_distance));
        end else begin
          want = answers.pop_front();
          got  = {out_value_3, out_value_2, out_value_1, out_value_0};
          if (out_code !== want.code)
            report($sformatf("code: expected %0d, got %0d", want.code, out_code));
          if (out_distance !== want.distance)
            report($sformatf("distance: expected %0d, got %0d", want.distance, out_distance));
          for (j = 0; j < LANES; j++)
            if (got[j] !== want.value[j])
              report($sformatf("value_%0d: expected %h, got %h", j, want.value[j], got[j]));
        end
      end
    end
    pending_count <= answers.size();
  end

endmodule

// File: tb/pq_nearest_centroid_encoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PQ nearest-centroid encoder testbench
// Loads three subspace codebooks, runs directed extremes and tie cases, then a
// random mix of writes, read-backs, encodes and undefined requests with random
// gaps on both channels. Reads and encodes only touch written entries.
// ----------------------------------------------------------------------------
module pq_nearest_centroid_encoder_unit_tb
  import pqnce_pkg::*;
;

  localparam int          RESET_CYCLES    = 10;
  localparam int          RANDOM_REQUESTS = 1160;
  localparam int          CYCLE_LIMIT     = 4_000_000;
  localparam logic [1:0]  FN_UNDEFINED    = 2'd3;
  localparam elem_t       ELEM_MIN        = 16'sh8000;
  localparam elem_t       ELEM_MAX        = 16'sh7fff;

  typedef enum int {FILL_MAX, FILL_CLUSTER, FILL_WIDE} fill_style_t;

  logic                clk;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_stall;
  logic [1:0]          in_func           = '0;
  logic [SUB_W-1:0]    in_subspace       = '0;
  logic [IN_IDX_W-1:0] in_centroid_index = '0;
  logic signed [15:0]  in_elem_0         = '0;
  logic signed [15:0]  in_elem_1         = '0;
  logic signed [15:0]  in_elem_2         = '0;
  logic signed [15:0]  in_elem_3         = '0;
  logic                out_valid;
  logic                out_stall         = 1'b0;
  logic [CODE_W-1:0]   out_code;
  logic [DIST_W-1:0]   out_distance;
  logic signed [15:0]  out_value_0;
  logic signed [15:0]  out_value_1;
  logic signed [15:0]  out_value_2;
  logic signed [15:0]  out_value_3;

  int errors;
  int pending;
  int cycle_count;
  bit no_idle = 1'b0;
  bit written [SUBSPACES][CODES];
  int fill_count [SUBSPACES];

  pq_nearest_centroid_encoder_unit uut (.*);

  pq_encode_checker u_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_subspace, .in_centroid_index,
    .in_elem_0, .in_elem_1, .in_elem_2, .in_elem_3,
    .out_valid, .out_stall, .out_code, .out_distance,
    .out_value_0, .out_value_1, .out_value_2, .out_value_3,
    .error_count(errors), .pending_count(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic elem_t rand_elem();
    int v;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = ELEM_MIN;
          1:       v = ELEM_MAX;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      1:       v = int'($urandom_range(0, 16)) - 8;
      default: v = int'($urandom);
    endcase
    return elem_t'(v);
  endfunction

  task automatic send_request(
    input logic [1:0]          func,
    input logic [SUB_W-1:0]    sub,
    input logic [IN_IDX_W-1:0] idx,
    input elem_t               e0,
    input elem_t               e1,
    input elem_t               e2,
    input elem_t               e3
  );
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_subspace       <= sub;
    in_centroid_index <= idx;
    in_elem_0         <= e0;
    in_elem_1         <= e1;
    in_elem_2         <= e2;
    in_elem_3         <= e3;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (func == FN_WRITE && !written[sub][idx]) begin
      written[sub][idx] = 1'b1;
      fill_count[sub]++;
    end
  endtask

  task automatic fill_subspace(input int sub, input fill_style_t style);
    int    k;
    int    j;
    elem_t e [LANES];
    for (k = 0; k < CODES; k++) begin
      for (j = 0; j < LANES; j++) begin
        case (style)
          FILL_MAX:     e[j] = ELEM_MAX;
          FILL_CLUSTER: e[j] = elem_t'(int'($urandom_range(0, 6)) - 3);
          default:      e[j] = rand_elem();
        endcase
      end
      send_request(FN_WRITE, SUB_W'(sub), IN_IDX_W'(k), e[0], e[1], e[2], e[3]);
    end
  endtask

  // result side: random stall before each result, then wait for it
  initial begin
    int hold;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int n;
    int pick;
    int sub;
    int idx;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    fill_subspace(7, FILL_MAX);
    fill_subspace(0, FILL_CLUSTER);
    fill_subspace(1, FILL_WIDE);
    send_request(FN_WRITE, 1, 0, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_request(FN_WRITE, 1, 255, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);

    // largest distance, and an all-way tie
    send_request(FN_ENCODE, 7, 8'hff, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_request(FN_ENCODE, 7, 8'h00, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_request(FN_ENCODE, 1, 8'h5a, ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN);
    send_request(FN_ENCODE, 1, 8'ha5, ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX);
    send_request(FN_ENCODE, 0, 8'h00, 0, 0, 0, 0);
    send_request(FN_ENCODE, 0, 8'hff, ELEM_MAX, ELEM_MIN, ELEM_MAX, ELEM_MIN);
    send_request(FN_WRITE, 2, 255, ELEM_MIN, ELEM_MAX, -1, 0);
    send_request(FN_READ, 2, 255, 0, 0, 0, 0);
    send_request(FN_READ, 1, 0, -1, -1, -1, -1);
    send_request(FN_READ, 7, 128, 0, 0, 0, 0);
    // exact match, then equal centroids: lowest index wins
    send_request(FN_WRITE, 0, 250, 1000, -1000, 500, -500);
    send_request(FN_ENCODE, 0, 0, 1000, -1000, 500, -500);
    send_request(FN_WRITE, 0, 251, 1000, -1000, 500, -500);
    send_request(FN_ENCODE, 0, 0, 1000, -1000, 500, -500);
    send_request(FN_WRITE, 0, 3, 1000, -1000, 500, -500);
    send_request(FN_ENCODE, 0, 0, 1000, -1000, 500, -500);
    send_request(FN_READ, 0, 251, 0, 0, 0, 0);
    send_request(FN_UNDEFINED, 5, 7, rand_elem(), rand_elem(), rand_elem(), rand_elem());
    send_request(FN_UNDEFINED, 7, 255, -1, -1, -1, -1);
    send_request(FN_WRITE, 6, 0, ELEM_MAX, ELEM_MIN, 1, -2);
    send_request(FN_READ, 6, 0, 0, 0, 0, 0);
    send_request(FN_ENCODE, 1, 0, rand_elem(), rand_elem(), rand_elem(), rand_elem());

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 0) no_idle <= ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, SUBSPACES - 1);
      idx  = $urandom_range(0, CODES - 1);
      if (pick < 40) begin
        send_request(FN_WRITE, SUB_W'(sub), IN_IDX_W'(idx),
                     rand_elem(), rand_elem(), rand_elem(), rand_elem());
      end else if (pick < 65) begin
        while (!written[sub][idx]) begin
          sub = $urandom_range(0, SUBSPACES - 1);
          idx = $urandom_range(0, CODES - 1);
        end
        send_request(FN_READ, SUB_W'(sub), IN_IDX_W'(idx),
                     rand_elem(), rand_elem(), rand_elem(), rand_elem());
      end else if (pick < 92) begin
        while (fill_count[sub] != CODES) sub = $urandom_range(0, SUBSPACES - 1);
        send_request(FN_ENCODE, SUB_W'(sub), IN_IDX_W'(idx),
                     rand_elem(), rand_elem(), rand_elem(), rand_elem());
      end else begin
        send_request(FN_UNDEFINED, SUB_W'(sub), IN_IDX_W'(idx),
                     rand_elem(), rand_elem(), rand_elem(), rand_elem());
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CODES + 16) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: pq_nearest_centroid_encoder_unit.f
+incdir+rtl
rtl/pqnce_pkg.sv
rtl/pqnce_ram.sv
rtl/pqnce_dp.sv
rtl/pqnce_ctrl.sv
rtl/pq_nearest_centroid_encoder_unit.sv
tb/pq_encode_checker.sv
tb/pq_nearest_centroid_encoder_unit_tb.sv
